>>> hw/rtl/fpr_pkg.sv
// Shared constants, types and state encoding for the FIFO page replacement core.
package fpr_pkg;

  localparam int unsigned DefFrames   = 16;
  localparam int unsigned DefPageBits = 16;
  localparam int unsigned PageW       = 16;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned CfgW        = 5;
  localparam int unsigned CountW      = 32;

  localparam logic [CfgW-1:0] NumFramesRst = CfgW'(16);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StVictim,
    StMiss,
    StDone
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic victim_rd;
    logic commit_hit;
    logic commit_miss;
    logic out_load;
  } fpr_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } fpr_sts_t;

endpackage

>>> hw/rtl/fifo_page_replacement_core.sv
// Top level of the FIFO page replacement core: sequencer plus datapath.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | page_i
//  out     | output    | out_valid_o/out_ready_i| hit_o slot_o evicted_valid_o
//          |           |                        | evicted_page_o fault_total_o
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (num_frames)
//
// A hit in slot k ends the scan there; a miss scans all n frames in use, then reads
// the victim. The scan reads one frame per cycle from the frame store, with a compare
// stage behind the registered read.
// Reset clears valid bits, pointer and fault count; num_frames resets to 16.
// The next word is taken while a finished result still waits on out_ready_i.
module fifo_page_replacement_core import fpr_pkg::*; #(
  parameter int unsigned FRAMES    = DefFrames,
  parameter int unsigned PAGE_BITS = DefPageBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PageW-1:0]  page_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [SlotW-1:0]  slot_o,
  output logic              evicted_valid_o,
  output logic [PageW-1:0]  evicted_page_o,
  output logic [CountW-1:0] fault_total_o
);

  fpr_cmd_t cmd;
  fpr_sts_t sts;

  fpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpr_dpath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .page_i          (page_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

>>> hw/rtl/fpr_ctrl.sv
// Sequencer: accept, scan frames (committing a hit), fetch victim, commit miss, hand off result.
module fpr_ctrl import fpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fpr_sts_t sts_i,
  output fpr_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          cmd_o.commit_hit = 1'b1;
          state_d          = StDone;
        end else if (sts_i.scan_end) begin
          state_d = StVictim;
        end
      end
      StVictim: begin
        cmd_o.victim_rd = 1'b1;
        state_d         = StMiss;
      end
      StMiss: begin
        cmd_o.commit_miss = 1'b1;
        state_d           = StDone;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

>>> hw/rtl/fpr_dpath.sv
// Frame store, valid bits, scan pipeline, round-robin pointer, fault counter, result regs.
module fpr_dpath import fpr_pkg::*; #(
  parameter int unsigned FRAMES    = DefFrames,
  parameter int unsigned PAGE_BITS = DefPageBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic [PageW-1:0]  page_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              hit_o,
  output logic [SlotW-1:0]  slot_o,
  output logic              evicted_valid_o,
  output logic [PageW-1:0]  evicted_page_o,
  output logic [CountW-1:0] fault_total_o,
  input  fpr_cmd_t          cmd_i,
  output fpr_sts_t          sts_o
);

  localparam int unsigned CntW = $clog2(FRAMES + 1);
  localparam int unsigned IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [PAGE_BITS-1:0] mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_q;
  logic [FRAMES-1:0]    frame_valid_q;

  logic [CfgW-1:0]      num_frames_q;
  logic [CntW-1:0]      n_cfg, n_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [CntW-1:0]      idx_q, idx_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [IdxW-1:0]      cmp_idx_q;
  logic [IdxW-1:0]      next_slot_q, next_slot_d;
  logic [IdxW-1:0]      victim_q, victim_d;
  logic [CntW-1:0]      victim_nxt;
  logic [CountW-1:0]    fault_q;

  logic                 issue, rd_en, hit_now, ev_v;
  logic [IdxW-1:0]      rd_addr;

  logic                 res_hit_q, res_ev_v_q;
  logic [IdxW-1:0]      res_slot_q;
  logic [PAGE_BITS-1:0] res_ev_page_q;

  logic                 out_valid_q;
  logic                 out_hit_q, out_ev_v_q;
  logic [IdxW-1:0]      out_slot_q;
  logic [PAGE_BITS-1:0] out_ev_page_q;
  logic [CountW-1:0]    out_fault_q;

  always_comb begin
    if (num_frames_q == '0) begin
      n_cfg = CntW'(1);
    end else if (32'(num_frames_q) > 32'(FRAMES)) begin
      n_cfg = CntW'(FRAMES);
    end else begin
      n_cfg = CntW'(num_frames_q);
    end
  end

  assign issue   = cmd_i.scan && (idx_q < n_q);
  assign rd_en   = issue || cmd_i.victim_rd;
  assign rd_addr = cmd_i.victim_rd ? victim_d : idx_q[IdxW-1:0];
  assign idx_d   = idx_q + CntW'(1);
  assign cmp_v_d = issue;
  assign hit_now = cmp_v_q && frame_valid_q[cmp_idx_q] && (rd_q == page_q);

  assign victim_d    = (CntW'(next_slot_q) < n_q) ? next_slot_q : '0;
  assign victim_nxt  = CntW'(victim_q) + CntW'(1);
  assign next_slot_d = (victim_nxt >= n_q) ? '0 : victim_nxt[IdxW-1:0];
  assign ev_v        = frame_valid_q[victim_q];

  assign sts_o.hit      = hit_now;
  assign sts_o.scan_end = !(idx_q < n_q) && !cmp_v_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_miss) begin
      mem[victim_q] <= page_q;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q  <= NumFramesRst;
      frame_valid_q <= '0;
      next_slot_q   <= '0;
      fault_q       <= '0;
      idx_q         <= '0;
      cmp_v_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_frames_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        idx_q   <= '0;
        cmp_v_q <= 1'b0;
      end else begin
        if (issue) begin
          idx_q <= idx_d;
        end
        cmp_v_q <= cmp_v_d;
      end
      if (cmd_i.commit_miss) begin
        frame_valid_q[victim_q] <= 1'b1;
        next_slot_q             <= next_slot_d;
        if (fault_q != '1) begin
          fault_q <= fault_q + CountW'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      page_q <= PAGE_BITS'(page_i);
      n_q    <= n_cfg;
    end
    if (issue) begin
      cmp_idx_q <= idx_q[IdxW-1:0];
    end
    if (cmd_i.victim_rd) begin
      victim_q <= victim_d;
    end
    if (cmd_i.commit_hit) begin
      res_hit_q     <= 1'b1;
      res_slot_q    <= cmp_idx_q;
      res_ev_v_q    <= 1'b0;
      res_ev_page_q <= '0;
    end else if (cmd_i.commit_miss) begin
      res_hit_q     <= 1'b0;
      res_slot_q    <= victim_q;
      res_ev_v_q    <= ev_v;
      res_ev_page_q <= ev_v ? rd_q : '0;
    end
    if (cmd_i.out_load) begin
      out_hit_q     <= res_hit_q;
      out_slot_q    <= res_slot_q;
      out_ev_v_q    <= res_ev_v_q;
      out_ev_page_q <= res_ev_page_q;
      out_fault_q   <= fault_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign slot_o          = SlotW'(out_slot_q);
  assign evicted_valid_o = out_ev_v_q;
  assign evicted_page_o  = PageW'(out_ev_page_q);
  assign fault_total_o   = out_fault_q;

endmodule
